// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

    localparam int WIDTH = 32;

    typedef struct packed {
        logic [31:0] base_value;
        logic [31:0] exponent_value;
        logic [31:0] modulus_value;
    } t_mexp_in;

    typedef struct packed {
        logic [31:0] power_result;
        logic        bad_modulus;
    } t_mexp_out;

    // classified job handed from front to back
    typedef struct packed {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] expo;
        logic [WIDTH-1:0] modulus;
        logic             trivial;   // result known without iteration
        logic [WIDTH-1:0] trivial_val;
        logic             bad;
    } t_mexp_job;

    // (x + y) mod m for x, y < m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        logic [WIDTH:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        add_mod = (s >= {1'b0, m}) ? d[WIDTH-1:0] : s[WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/mexp_front.sv =====
module mexp_front
    import mexp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_mexp_in  i_item,
    output logic      o_job_valid,
    input  logic      i_job_take,
    output t_mexp_job o_job
);
    // two-entry queue of classified jobs
    t_mexp_job r_q [2];
    logic      r_wp;
    logic      r_rp;
    logic [1:0] r_cnt;
    t_mexp_job n_job;
    logic      w_push;
    logic      w_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_job_take && o_job_valid;

    always_comb begin
        n_job.base        = i_item.base_value[WIDTH-1:0];
        n_job.expo        = i_item.exponent_value[WIDTH-1:0];
        n_job.modulus     = i_item.modulus_value[WIDTH-1:0];
        n_job.bad         = (n_job.modulus == '0);
        n_job.trivial     = n_job.bad || (n_job.expo == '0) || (n_job.modulus == WIDTH'(1));
        if (n_job.bad) begin
            n_job.trivial_val = '0;
        end else if (n_job.expo == '0) begin
            n_job.trivial_val = WIDTH'(1);
        end else begin
            n_job.trivial_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== rtl/mexp_back.sv =====
module mexp_back
    import mexp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_take,
    input  t_mexp_job i_job,
    output logic      o_empty,
    input  logic      i_pop,
    output t_mexp_out o_res
);
    localparam int CW = $clog2(WIDTH + 1);
    localparam int IW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE, S_REDUCE, S_MUL, S_STEP, S_OUT
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_b;        // running square
    logic [WIDTH-1:0] r_acc;      // running result
    logic [WIDTH-1:0] r_pa;       // product accumulators
    logic [WIDTH-1:0] r_pb;
    logic [WIDTH-1:0] r_da;       // doubled addends
    logic [WIDTH-1:0] r_db;
    logic [WIDTH-1:0] r_mb;       // multiplier bits
    logic [CW-1:0]    r_cnt;
    logic [WIDTH:0]   r_rem;      // base reduction remainder
    logic             r_bad;
    logic             r_full;
    t_mexp_out        r_res;
    logic [WIDTH:0]   w_sh;
    logic             w_load;

    assign o_empty    = !r_full;
    assign o_res      = r_res;
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign w_sh       = {r_rem[WIDTH-1:0], r_b[WIDTH-1]};
    // output register takes the finished beat once the waiting one leaves
    assign w_load     = (r_state == S_OUT) && (!r_full || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
        end else begin
            if (w_load)     r_full <= 1'b1;
            else if (i_pop) r_full <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_m   <= i_job.modulus;
                        r_e   <= i_job.expo;
                        r_b   <= i_job.base;
                        r_acc <= i_job.trivial ? i_job.trivial_val : WIDTH'(1);
                        r_bad <= i_job.bad;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= i_job.trivial ? S_OUT : S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    // restoring division, one bit a cycle, keep remainder
                    r_b <= {r_b[WIDTH-2:0], 1'b0};
                    if (w_sh >= {1'b0, r_m}) r_rem <= w_sh - {1'b0, r_m};
                    else                     r_rem <= w_sh;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(WIDTH - 1)) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_cnt == CW'(WIDTH)) begin
                        r_b <= r_rem[WIDTH-1:0];
                    end
                    if (r_e == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        // acc*b and b*b together
                        r_pa  <= '0;
                        r_pb  <= '0;
                        r_da  <= (r_cnt == CW'(WIDTH)) ? r_rem[WIDTH-1:0] : r_b;
                        r_db  <= (r_cnt == CW'(WIDTH)) ? r_rem[WIDTH-1:0] : r_b;
                        r_mb  <= r_acc;
                        r_cnt <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_e[0] && r_mb[0]) r_pa <= add_mod(r_pa, r_da, r_m);
                    if (r_b[r_cnt[IW-1:0]]) r_pb <= add_mod(r_pb, r_db, r_m);
                    r_da  <= add_mod(r_da, r_da, r_m);
                    r_db  <= add_mod(r_db, r_db, r_m);
                    r_mb  <= r_mb >> 1;
                    if (r_cnt == CW'(WIDTH - 1)) begin
                        if (r_e[0]) begin
                            r_acc <= (r_mb[0]) ? add_mod(r_pa, r_da, r_m) : r_pa;
                        end
                        r_b <= r_b[r_cnt[IW-1:0]] ? add_mod(r_pb, r_db, r_m) : r_pb;
                        r_e <= r_e >> 1;
                        r_cnt <= CW'(WIDTH + 1);
                        r_state <= S_STEP;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_res.power_result <= 32'(r_acc);
                        r_res.bad_modulus  <= r_bad;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/modular_exponentiation_unit.sv =====
// Run time grows with the bit length of the exponent: one multiply pass per exponent bit.
// Throughput: one item at a time in the back end; set by the bit-serial modular multiplier.
// Trivial cases (zero modulus, zero exponent, unit modulus) skip the reduction and multiply loops.
// A two-entry job queue accepts items while the back end works.
// Reset: synchronous active-low i_rst_n; clears queues and state, no clearing pass.
module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_mexp_in  i_item,
    output logic      o_empty,
    input  logic      i_pop,
    output t_mexp_out o_result
);
    logic      w_jv;
    logic      w_jt;
    t_mexp_job w_job;

    mexp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_item(i_item), .o_job_valid(w_jv), .i_job_take(w_jt), .o_job(w_job)
    );

    mexp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_jv), .o_job_take(w_jt),
        .i_job(w_job), .o_empty(o_empty), .i_pop(i_pop), .o_res(o_result)
    );

`ifndef NO_ASSERTIONS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.bad_modulus) |-> (o_result.power_result == 32'd0))
        else $error("bad modulus with nonzero result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("result changed while waiting");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_jt |-> w_jv)
        else $error("job taken from empty queue");
`endif
endmodule
